FILE: src/lap3d_pkg.sv
package lap3d_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    localparam int SIZE_X_BITS = 9;
    localparam int SIZE_Y_BITS = 7;
    localparam int SIZE_Z_BITS = 7;

    localparam logic [SIZE_X_BITS-1:0] SIZE_X_RESET = SIZE_X_BITS'(64);
    localparam logic [SIZE_Y_BITS-1:0] SIZE_Y_RESET = SIZE_Y_BITS'(64);
    localparam logic [SIZE_Z_BITS-1:0] SIZE_Z_RESET = SIZE_Z_BITS'(64);

    // smallest grid extent along any axis
    localparam int MIN_SIZE = 3;

    // extra result bits over a sample: six neighbours minus six times the centre
    localparam int LAP_EXTRA_BITS = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } cfg_reg_t;

endpackage

FILE: src/lap3d_ram.sv
module lap3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // read-first: a read of the entry being written returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/laplacian_7point_3d_stencil.sv
// Streaming seven-point 3D Laplacian. Samples (signed Q8.8) arrive in raster order, innermost
// axis fastest, one sample per clock cycle while s_ready is high; the result for the centre
// one plane behind passes stages 1 and 2 into the output register. Throughput is set by the
// two dual-read plane stores, which supply the four stored neighbours of each accepted sample;
// the left and centre samples of a row are kept in registers from earlier reads. No result
// comes from first-plane samples or is centred on the final plane. Boundary centres give a
// zero Laplacian with interior low; last marks the final centre of the grid. Writing any size
// register restarts the stream at the grid origin. Sizes are taken clamped to 3 up to MAX_*.
module laplacian_7point_3d_stencil
    import lap3d_pkg::*;
#(
    parameter int MAX_X       = 256,
    parameter int MAX_Y       = 64,
    parameter int MAX_Z       = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                cfg_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [SAMPLE_BITS-1:0]           s_sample,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [SAMPLE_BITS+LAP_EXTRA_BITS-1:0] m_laplacian,
    output logic                                    m_interior,
    output logic                                    m_last
);

    localparam int LW    = SAMPLE_BITS + LAP_EXTRA_BITS;
    localparam int XW    = $clog2(MAX_X);
    localparam int YW    = $clog2(MAX_Y);
    localparam int ZW    = $clog2(MAX_Z);
    localparam int NXW   = $clog2(MAX_X + 1);
    localparam int NYW   = $clog2(MAX_Y + 1);
    localparam int NZW   = $clog2(MAX_Z + 1);
    localparam int AW    = 1 + YW + ZW;
    localparam int DEPTH = 2 ** AW;

    // configuration
    logic [SIZE_X_BITS-1:0] size_x_reg;
    logic [SIZE_Y_BITS-1:0] size_y_reg;
    logic [SIZE_Z_BITS-1:0] size_z_reg;
    logic                   restart;

    logic [NXW-1:0] nx;
    logic [NYW-1:0] ny;
    logic [NZW-1:0] nz;
    logic [XW-1:0]  x_end;
    logic [YW-1:0]  y_end;
    logic [ZW-1:0]  z_end;

    // input position
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;

    logic accept;
    logic at_x_end, at_y_end, at_z_end;
    logic centre_inner, centre_last, has_result;

    // store addresses
    logic          par_cur, par_prev;
    logic [AW-1:0] addr_cur, addr_right, addr_down, addr_up;
    logic [SAMPLE_BITS-1:0] rd_cur, rd_right, rd_down, rd_up;
    logic signed [SAMPLE_BITS-1:0] back_s, right_s, down_s, up_s;

    // pipeline
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic m_valid_reg, m_valid_next;
    logic out_free, free2, free1, mv1, mv2;

    logic signed [SAMPLE_BITS-1:0] s1_reg;
    logic                          inner1_reg, last1_reg, row_start1_reg;
    logic signed [SAMPLE_BITS-1:0] hold_c_reg, hold_l_reg;

    logic signed [LW-1:0] pa_reg, pa_next;
    logic signed [LW-1:0] pb_reg, pb_next;
    logic                 inner2_reg, last2_reg;

    logic signed [LW-1:0] lap_reg;
    logic                 interior_reg, last_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_comb begin
        restart = 1'b0;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X: restart = 1'b1;
                REG_SIZE_Y: restart = 1'b1;
                REG_SIZE_Z: restart = 1'b1;
                default:    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_X_RESET;
            size_y_reg <= SIZE_Y_RESET;
            size_z_reg <= SIZE_Z_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X: size_x_reg <= cfg_data[SIZE_X_BITS-1:0];
                REG_SIZE_Y: size_y_reg <= cfg_data[SIZE_Y_BITS-1:0];
                REG_SIZE_Z: size_z_reg <= cfg_data[SIZE_Z_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(size_x_reg) < MIN_SIZE)    nx = NXW'(MIN_SIZE);
        else if (32'(size_x_reg) > MAX_X)  nx = NXW'(MAX_X);
        else                               nx = NXW'(size_x_reg);
        if (32'(size_y_reg) < MIN_SIZE)    ny = NYW'(MIN_SIZE);
        else if (32'(size_y_reg) > MAX_Y)  ny = NYW'(MAX_Y);
        else                               ny = NYW'(size_y_reg);
        if (32'(size_z_reg) < MIN_SIZE)    nz = NZW'(MIN_SIZE);
        else if (32'(size_z_reg) > MAX_Z)  nz = NZW'(MAX_Z);
        else                               nz = NZW'(size_z_reg);
    end

    assign x_end = XW'(nx - NXW'(1));
    assign y_end = YW'(ny - NYW'(1));
    assign z_end = ZW'(nz - NZW'(1));

    // ------------------------------------------------------------------
    // handshake and position
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign free2    = !v2_reg || out_free;
    assign mv2      = v2_reg && out_free;
    assign free1    = !v1_reg || free2;
    assign mv1      = v1_reg && free2;
    assign s_ready  = free1;
    assign accept   = s_valid && s_ready;

    assign at_x_end = (x_reg == x_end);
    assign at_y_end = (y_reg == y_end);
    assign at_z_end = (z_reg == z_end);

    // centre is (x-1, y, z)
    assign has_result   = (x_reg != '0);
    assign centre_inner = (x_reg >= XW'(2)) && (y_reg != '0) && !at_y_end
                          && (z_reg != '0) && !at_z_end;
    assign centre_last  = at_x_end && at_y_end && at_z_end;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (restart) begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end else if (accept) begin
            if (at_z_end) begin
                z_next = '0;
                if (at_y_end) begin
                    y_next = '0;
                    x_next = at_x_end ? '0 : x_reg + XW'(1);
                end else begin
                    y_next = y_reg + YW'(1);
                end
            end else begin
                z_next = z_reg + ZW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // ------------------------------------------------------------------
    // plane stores: two copies, each written with the incoming sample
    // ------------------------------------------------------------------
    assign par_cur  = x_reg[0];
    assign par_prev = ~x_reg[0];

    assign addr_cur   = {par_cur, y_reg, z_reg};
    assign addr_right = {par_prev, y_reg, z_reg + ZW'(1)};
    assign addr_up    = {par_prev, y_reg + YW'(1), z_reg};
    // at a row start the lower-row port fetches the left-hand sample instead
    assign addr_down  = (z_reg == '0) ? {par_prev, y_reg, z_reg}
                                      : {par_prev, y_reg - YW'(1), z_reg};

    lap3d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store_a (
        .aclk    (aclk),
        .we      (accept),
        .waddr   (addr_cur),
        .wdata   (s_sample),
        .re      (accept),
        .raddr_a (addr_cur),
        .raddr_b (addr_right),
        .rdata_a (rd_cur),
        .rdata_b (rd_right)
    );

    lap3d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store_b (
        .aclk    (aclk),
        .we      (accept),
        .waddr   (addr_cur),
        .wdata   (s_sample),
        .re      (accept),
        .raddr_a (addr_down),
        .raddr_b (addr_up),
        .rdata_a (rd_down),
        .rdata_b (rd_up)
    );

    assign back_s  = rd_cur;
    assign right_s = rd_right;
    assign down_s  = rd_down;
    assign up_s    = rd_up;

    // ------------------------------------------------------------------
    // stage 1: store data valid
    // ------------------------------------------------------------------
    always_comb begin
        v1_next = v1_reg;
        if (accept)   v1_next = has_result;
        else if (mv1) v1_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg         <= s_sample;
            inner1_reg     <= centre_inner;
            last1_reg      <= centre_last;
            row_start1_reg <= (z_reg == '0);
        end
    end

    // centre and left samples of the previous plane, carried along the row
    always_ff @(posedge aclk) begin
        if (mv1) begin
            hold_c_reg <= right_s;
            hold_l_reg <= row_start1_reg ? down_s : hold_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: partial sums
    // ------------------------------------------------------------------
    assign pa_next = LW'(s1_reg) + LW'(back_s) + LW'(up_s) + LW'(down_s);
    assign pb_next = LW'(right_s) + LW'(hold_l_reg)
                     - (LW'(hold_c_reg) <<< 2) - (LW'(hold_c_reg) <<< 1);

    always_comb begin
        v2_next = v2_reg;
        if (mv1)      v2_next = 1'b1;
        else if (mv2) v2_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv1) begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            inner2_reg <= inner1_reg;
            last2_reg  <= last1_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (mv2)          m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv2) begin
            lap_reg      <= inner2_reg ? pa_reg + pb_reg : '0;
            interior_reg <= inner2_reg;
            last_reg     <= last2_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_laplacian = lap_reg;
    assign m_interior  = interior_reg;
    assign m_last      = last_reg;

`ifndef SYNTHESIS
    a_boundary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_interior |-> m_laplacian == '0)
        else $error("boundary centre with nonzero result");

    a_last_is_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_interior)
        else $error("final centre flagged interior");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> x_reg == '0 && y_reg == '0 && z_reg == '0)
        else $error("size write did not restart the stream");

    a_grid_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !restart && centre_last |=> x_reg == '0 && y_reg == '0 && z_reg == '0)
        else $error("position did not wrap after the final sample");

    a_no_first_plane_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !has_result |=> !v1_reg)
        else $error("first-plane transfer entered the pipeline");
`endif

endmodule
